// ===== rtl/core/dhwi_pkg.sv =====
// Package: shared constants and types of the double hash word insert block.
package dhwi_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_WORD    = 15;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = 11;
  localparam int LEN_W       = 5;
  localparam int HASH_W      = 32;
  localparam logic [SIZE_W-1:0] COUNT_LIMIT = 11'd2047;

  localparam logic [1:0] STATUS_STORED  = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_TOOLONG = 2'd2;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_MAX_LOAD   = 1'b1;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } div_rsp_t;
endpackage

// ===== rtl/core/dhwi_if.sv =====
// Interfaces: letter input channel and result output channel.
interface dhwi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] letter;
  logic       last_letter;
  modport source (output valid, letter, last_letter, input ready);
  modport sink   (input valid, letter, last_letter, output ready);
endinterface

interface dhwi_out_if;
  logic                       valid;
  logic                       ready;
  logic [dhwi_pkg::SLOT_W-1:0] slot;
  logic [1:0]                 status;
  logic                       over_load;
  modport source (output valid, slot, status, over_load, input ready);
  modport sink   (input valid, slot, status, over_load, output ready);
endinterface

// ===== rtl/core/dhwi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dhwi_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/dhwi_moddiv.sv =====
// Restoring modulo unit: one dividend bit per cycle.
module dhwi_moddiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dhwi_pkg::div_req_t req_i,
  output dhwi_pkg::div_rsp_t rsp_o
);
  logic [dhwi_pkg::HASH_W-1:0] dvd_q;
  logic [dhwi_pkg::SIZE_W-1:0] dvs_q, rem_q;
  logic [5:0]                  cnt_q;
  logic                        busy_q, done_q;
  logic [dhwi_pkg::SIZE_W:0]   trial;
  logic [dhwi_pkg::SIZE_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[dhwi_pkg::HASH_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = dhwi_pkg::SIZE_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[dhwi_pkg::SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[dhwi_pkg::HASH_W-2:0], 1'b0};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(dhwi_pkg::HASH_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;
endmodule

// ===== rtl/core/double_hash_word_insert.sv =====
// Top level: letter collection, hash sequencer and probe walk over the slot map.
//
//  channel   dir  payload                         handshake
//  in_ch     in   letter[7:0], last_letter        valid/ready
//  out_ch    out  slot[9:0], status[1:0], over_load valid/ready
//  cfg       in   cfg_idx_i, cfg_data_i[10:0]     cfg_we_i
//
// A plain letter is taken without leaving ST_IDLE. A last letter of a word
// under the length limit runs two reductions in the shared modulo unit, then
// one slot map RAM read and check per probe. After reset a clearing pass
// sweeps all 1024 slots while in_ch.ready stays low. A stalled result holds in
// the output register; letters are still taken until the next result is due.
module double_hash_word_insert (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dhwi_in_if.sink                     in_ch,
  dhwi_out_if.source                  out_ch,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [dhwi_pkg::SIZE_W-1:0] cfg_data_i
);
  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_P1, ST_P2, ST_H1, ST_H1W, ST_H2W, ST_RD, ST_CHK, ST_OUT
  } state_e;

  localparam int SW = dhwi_pkg::SIZE_W;
  localparam int AW = dhwi_pkg::SLOT_W;

  state_e state_q;
  logic [SW-1:0] tsize_q, maxld_q, count_q, clr_q;
  logic [31:0]   poly_q, dvd_q;
  logic [7:0]    first_q, second_q, prior_q, latest_q;
  logic [dhwi_pkg::LEN_W-1:0] len_q, len_d;
  logic [16:0]   sum_q;
  logic [SW-1:0] h1_q, h2_q, t_q, t_step;
  logic [1:0]    res_status_q;
  logic [AW-1:0] res_slot_q;
  logic          ov_q;
  logic [AW-1:0] out_slot_q;
  logic [1:0]    out_status_q;
  logic          out_ovl_q;

  logic [SW-1:0] sz;
  dhwi_pkg::div_req_t div_req;
  dhwi_pkg::div_rsp_t div_rsp;
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr;
  logic          in_fire, out_free;

  always_comb begin
    if (tsize_q < SW'(2)) begin
      sz = SW'(2);
    end else if (tsize_q > SW'(dhwi_pkg::TABLE_DEPTH)) begin
      sz = SW'(dhwi_pkg::TABLE_DEPTH);
    end else begin
      sz = tsize_q;
    end
  end

  always_comb begin
    if (t_q < h2_q) begin
      t_step = SW'(t_q + sz - h2_q);
    end else begin
      t_step = SW'(t_q - h2_q);
    end
  end

  assign len_d    = (len_q < dhwi_pkg::LEN_W'(dhwi_pkg::MAX_WORD)) ? len_q + 1'b1 : len_q;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !ov_q || out_ch.ready;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = dvd_q;
    div_req.divisor  = sz;
    if (state_q == ST_H1) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_H1W && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = poly_q;
      div_req.divisor  = SW'(sz - 1'b1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = t_q[AW-1:0];
    ram_wdata = 1'b1;
    if (state_q == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q[AW-1:0];
      ram_wdata = 1'b0;
    end else if (state_q == ST_CHK && !ram_rdata) begin
      ram_we = 1'b1;
    end
  end

  dhwi_moddiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dhwi_ram #(.WIDTH(1), .DEPTH(dhwi_pkg::TABLE_DEPTH)) u_used (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (t_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      tsize_q  <= SW'(1021);
      maxld_q  <= SW'(612);
      count_q  <= '0;
      clr_q    <= '0;
      poly_q   <= '0;
      first_q  <= '0;
      second_q <= '0;
      prior_q  <= '0;
      latest_q <= '0;
      len_q    <= '0;
      ov_q     <= 1'b0;
      t_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dhwi_pkg::CFG_TABLE_SIZE: tsize_q <= cfg_data_i;
          dhwi_pkg::CFG_MAX_LOAD:   maxld_q <= cfg_data_i;
          default: ;
        endcase
      end
      // load a new result or drop the one just taken
      if (state_q == ST_OUT && out_free) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ch.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SW'(dhwi_pkg::TABLE_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.last_letter &&
                len_d >= dhwi_pkg::LEN_W'(dhwi_pkg::MAX_WORD)) begin
              res_status_q <= dhwi_pkg::STATUS_TOOLONG;
              res_slot_q   <= '0;
              state_q      <= ST_OUT;
              poly_q   <= '0;
              first_q  <= '0;
              second_q <= '0;
              prior_q  <= '0;
              latest_q <= '0;
              len_q    <= '0;
            end else begin
              len_q    <= len_d;
              if (len_d == dhwi_pkg::LEN_W'(1)) first_q  <= in_ch.letter;
              if (len_d == dhwi_pkg::LEN_W'(2)) second_q <= in_ch.letter;
              prior_q  <= latest_q;
              latest_q <= in_ch.letter;
              poly_q   <= {poly_q[26:0], 5'b0} - poly_q + {24'b0, in_ch.letter};
              if (in_ch.last_letter) begin
                state_q <= ST_P1;
              end
            end
          end
        end
        ST_P1: begin
          sum_q   <= ({9'b0, first_q} * {9'b0, second_q}) +
                     ({9'b0, latest_q} * {9'b0, prior_q});
          state_q <= ST_P2;
        end
        ST_P2: begin
          dvd_q   <= {15'b0, sum_q} * {27'b0, len_q};
          state_q <= ST_H1;
        end
        ST_H1: state_q <= ST_H1W;
        ST_H1W: begin
          if (div_rsp.done) begin
            h1_q     <= div_rsp.rem;
            t_q      <= div_rsp.rem;
            state_q  <= ST_H2W;
            poly_q   <= '0;
            first_q  <= '0;
            second_q <= '0;
            prior_q  <= '0;
            latest_q <= '0;
            len_q    <= '0;
          end
        end
        ST_H2W: begin
          if (div_rsp.done) begin
            h2_q    <= div_rsp.rem + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_RD: state_q <= ST_CHK;
        ST_CHK: begin
          if (!ram_rdata) begin
            if (count_q < dhwi_pkg::COUNT_LIMIT) count_q <= count_q + 1'b1;
            res_status_q <= dhwi_pkg::STATUS_STORED;
            res_slot_q   <= t_q[AW-1:0];
            state_q      <= ST_OUT;
          end else if (t_step == h1_q) begin
            res_status_q <= dhwi_pkg::STATUS_FULL;
            res_slot_q   <= '0;
            state_q      <= ST_OUT;
          end else begin
            t_q     <= t_step;
            state_q <= ST_RD;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_slot_q   <= res_slot_q;
            out_status_q <= res_status_q;
            out_ovl_q    <= (count_q > maxld_q);
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = ov_q;
  assign out_ch.slot      = out_slot_q;
  assign out_ch.status    = out_status_q;
  assign out_ch.over_load = out_ovl_q;
endmodule
